// File: hdl/bhra_pkg.sv
// Package for the bucketed history ring averager.
// Types, operation codes, register indexes and sizing constants; no dependencies.
`timescale 1ns / 1ps
package bhra_pkg;
  localparam int METRICS_DEF   = 4;
  localparam int SAMPLES_DEF   = 1440;
  localparam int MAX_SLOTS_DEF = 64;

  localparam logic [2:0] OP_ADD    = 3'd0;
  localparam logic [2:0] OP_TICK   = 3'd1;
  localparam logic [2:0] OP_SERIES = 3'd2;
  localparam logic [2:0] OP_STATS  = 3'd3;
  localparam logic [2:0] OP_SPAN   = 3'd4;

  localparam logic REG_BUCKET_TICKS = 1'b0;
  localparam logic REG_NO_DATA      = 1'b1;

  localparam logic [31:0] BUCKET_TICKS_RST = 32'd60000;
  localparam logic [15:0] NO_DATA_RST      = 16'h8000;

  // Command handed from the front end to the back end through the queue.
  typedef struct packed {
    logic [2:0] op;
    logic [3:0] metric;
    logic [15:0] value;
    logic [6:0] slots;
    logic       bad;
  } cmd_t;
endpackage

// File: hdl/bhra_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module bhra_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem_r[addr] <= wdata;
    rdata <= mem_r[addr];
  end
endmodule

// File: hdl/bhra_front.sv
// Front end: input acceptance, validation and a two-entry command queue.
// Depends on bhra_pkg.
`timescale 1ns / 1ps
module bhra_front #(
  parameter int METRICS   = bhra_pkg::METRICS_DEF,
  parameter int MAX_SLOTS = bhra_pkg::MAX_SLOTS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  logic [2:0]     op,
  input  logic [3:0]     metric,
  input  logic [15:0]    value,
  input  logic [6:0]     slots,
  output logic           q_valid,
  output bhra_pkg::cmd_t q_cmd,
  input  logic           q_pop
);
  bhra_pkg::cmd_t q_r [2];
  logic [1:0] cnt_r;
  logic       rd_r, wr_r;
  logic       push;
  bhra_pkg::cmd_t c;

  always_comb begin
    c.op = op;
    c.metric = metric;
    c.value = value;
    c.slots = (slots > 7'(MAX_SLOTS)) ? 7'(MAX_SLOTS) : slots;
    c.bad = ({28'd0, metric} >= 32'(METRICS)) || (op == bhra_pkg::OP_SERIES && slots == 7'd0);
  end

  assign busy    = (cnt_r == 2'd2);
  assign push    = start && !busy && op <= bhra_pkg::OP_SPAN;
  assign q_valid = (cnt_r != 2'd0);
  assign q_cmd   = q_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) q_r[wr_r] <= c;
    if (!rst_n) begin
      cnt_r <= 2'd0;
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
    end else begin
      if (push) wr_r <= !wr_r;
      if (q_pop) rd_r <= !rd_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
    else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("queue overflow");
  assert property (@(posedge clk) disable iff (!rst_n) (busy && !q_pop) |=> busy)
    else $error("queue lost entry");
endmodule

// File: hdl/bhra_div.sv
// Radix-2 restoring divider for signed sums over unsigned counts, truncating.
// No dependencies.
`timescale 1ns / 1ps
module bhra_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic [31:0] num,
  input  logic [15:0] den,
  output logic        done,
  output logic [15:0] quo
);
  logic [31:0] q_r, r_r;
  logic [15:0] d_r;
  logic        neg_r, run_r, done_r;
  logic [5:0]  n_r;
  logic [32:0] trial;
  logic [31:0] mag;

  assign mag   = num[31] ? (~num + 32'd1) : num;
  assign trial = {r_r, q_r[31]} - {17'd0, d_r};
  assign done  = done_r;
  assign quo   = neg_r ? 16'(~q_r + 32'd1) : q_r[15:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        q_r <= mag;
        r_r <= 32'd0;
        d_r <= den;
        neg_r <= num[31];
        n_r <= 6'd0;
        run_r <= 1'b1;
      end else if (run_r) begin
        if (!trial[32]) begin
          r_r <= trial[31:0];
          q_r <= {q_r[30:0], 1'b1};
        end else begin
          r_r <= {r_r[30:0], q_r[31]};
          q_r <= {q_r[30:0], 1'b0};
        end
        n_r <= n_r + 6'd1;
        if (n_r == 6'd31) begin
          run_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end
endmodule

// File: hdl/bhra_back.sv
// Back end: bucket accumulators, tick counter, ring walk for reads and result drive.
// Depends on bhra_pkg, bhra_ram and bhra_div.
`timescale 1ns / 1ps
module bhra_back #(
  parameter int METRICS   = bhra_pkg::METRICS_DEF,
  parameter int SAMPLES   = bhra_pkg::SAMPLES_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  bhra_pkg::cmd_t q_cmd,
  output logic           q_pop,
  input  logic [31:0]    bucket_ticks,
  input  logic [15:0]    no_data,
  output logic           out_strobe,
  output logic [15:0]    out_slot_value,
  output logic           out_slot_has_data,
  output logic           out_is_last,
  output logic [6:0]     out_valid_total,
  output logic [15:0]    out_min_value,
  output logic [15:0]    out_max_value,
  output logic [15:0]    out_avg_value,
  output logic           out_stats_ok,
  output logic [10:0]    out_sample_count
);
  localparam int MW    = (METRICS > 1) ? $clog2(METRICS) : 1;
  localparam int SW    = $clog2(SAMPLES);
  localparam int CW    = $clog2(SAMPLES + 1);
  localparam int DEPTH = METRICS * SAMPLES;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [9:0] {
    S_CLEAR = 10'b0000000001, S_IDLE  = 10'b0000000010, S_CLOSE = 10'b0000000100,
    S_CDIV  = 10'b0000001000, S_SLOT  = 10'b0000010000, S_RD    = 10'b0000100000,
    S_ACC   = 10'b0001000000, S_DIV   = 10'b0010000000, S_EMIT  = 10'b0100000000,
    S_SBND  = 10'b1000000000
  } st_t;
  st_t st_r;

  logic [SW-1:0]  head_r [METRICS];
  logic [CW-1:0]  stored_r [METRICS];
  logic [31:0]    bsum_r [METRICS];
  logic [15:0]    brd_r [METRICS];
  logic [31:0]    tick_r;
  logic [AW-1:0]  clr_r;
  logic [MW-1:0]  m_r;
  bhra_pkg::cmd_t cmd_r;
  logic [CW-1:0]  cnt_r, k_r, hi_r;
  logic [SW-1:0]  pos_r, base_r;
  logic [6:0]     i_r, vt_r;
  logic [31:0]    sum_r;
  logic [15:0]    c_r, mn_r, mx_r;

  logic           we;
  logic [AW-1:0]  addr;
  logic [15:0]    wdata, rdata;
  logic           dgo, ddone;
  logic [31:0]    dnum;
  logic [15:0]    dden, dquo;
  logic [31:0]    prod;
  logic           walk_done;
  logic [31:0]    lo_pos;

  bhra_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata));
  bhra_div u_div (
    .clk(clk), .rst_n(rst_n), .go(dgo), .num(dnum), .den(dden), .done(ddone), .quo(dquo));

  function automatic logic [SW-1:0] wrap_inc(input logic [SW-1:0] p);
    wrap_inc = (32'(p) + 32'd1 >= 32'(SAMPLES)) ? '0 : p + SW'(1);
  endfunction

  // Slot bounds: quotient and remainder of (i+1)*cnt/n carry from slot to slot,
  // so each slot only steps its upper bound forward by about cnt/n subtracts.
  logic [31:0] rem_lo_r, rem_hi_r;
  logic [CW-1:0] qlo_r, qhi_r;
  assign prod = 32'(cnt_r);

  assign walk_done = (cnt_r == '0) || (k_r >= hi_r);
  assign lo_pos    = 32'(base_r) + 32'(qlo_r);

  logic idle_read;
  assign idle_read = (st_r == S_IDLE) && q_valid;

  always_comb begin
    we = 1'b0; addr = '0; wdata = no_data;
    dgo = 1'b0; dnum = sum_r; dden = c_r;
    if (st_r == S_CLEAR) begin
      we = 1'b1; addr = clr_r; wdata = bhra_pkg::NO_DATA_RST;
    end else if (st_r == S_CLOSE) begin
      addr = AW'(32'(m_r) * 32'(SAMPLES) + 32'(head_r[m_r]));
      if (brd_r[m_r] == 16'd0) we = 1'b1;
      else begin
        dgo = 1'b1; dnum = bsum_r[m_r]; dden = brd_r[m_r];
      end
    end else if (st_r == S_CDIV) begin
      addr = AW'(32'(m_r) * 32'(SAMPLES) + 32'(head_r[m_r]));
      wdata = dquo; we = ddone;
    end else begin
      addr = AW'(32'(m_r) * 32'(SAMPLES) + 32'(pos_r));
      if (st_r == S_SLOT && walk_done && c_r != 16'd0) dgo = 1'b1;
    end
  end

  assign q_pop = idle_read;

  logic signed [15:0] rv;
  assign rv = rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLEAR;
      clr_r <= '0;
      tick_r <= 32'd0;
      out_strobe <= 1'b0;
      for (int m = 0; m < METRICS; m++) begin
        head_r[m] <= '0; stored_r[m] <= '0; bsum_r[m] <= '0; brd_r[m] <= '0;
      end
    end else begin
      out_strobe <= 1'b0;
      unique case (st_r)
        S_CLEAR: begin
          clr_r <= clr_r + AW'(1);
          if (32'(clr_r) == 32'(DEPTH - 1)) st_r <= S_IDLE;
        end
        S_IDLE: if (q_valid) begin
          cmd_r <= q_cmd;
          m_r <= (q_cmd.op == bhra_pkg::OP_TICK) ? '0 : MW'(q_cmd.metric);
          unique case (q_cmd.op)
            bhra_pkg::OP_ADD: begin
              if (!q_cmd.bad && brd_r[MW'(q_cmd.metric)] != 16'hFFFF) begin
                bsum_r[MW'(q_cmd.metric)] <= bsum_r[MW'(q_cmd.metric)] +
                  {{16{q_cmd.value[15]}}, q_cmd.value};
                brd_r[MW'(q_cmd.metric)] <= brd_r[MW'(q_cmd.metric)] + 16'd1;
              end
            end
            bhra_pkg::OP_TICK: begin
              if (((tick_r == 32'hFFFF_FFFF) ? tick_r : tick_r + 32'd1) >= bucket_ticks) begin
                tick_r <= 32'd0;
                st_r <= S_CLOSE;
              end else if (tick_r != 32'hFFFF_FFFF) tick_r <= tick_r + 32'd1;
            end
            default: begin
              if (q_cmd.bad) begin
                out_strobe <= 1'b1;
                out_slot_value <= '0; out_slot_has_data <= 1'b0; out_is_last <= 1'b1;
                out_valid_total <= '0; out_min_value <= '0; out_max_value <= '0;
                out_avg_value <= '0; out_stats_ok <= 1'b0; out_sample_count <= '0;
              end else if (q_cmd.op == bhra_pkg::OP_SPAN) begin
                out_strobe <= 1'b1;
                out_slot_value <= '0; out_slot_has_data <= 1'b0; out_is_last <= 1'b1;
                out_valid_total <= '0; out_min_value <= '0; out_max_value <= '0;
                out_avg_value <= '0; out_stats_ok <= 1'b0;
                out_sample_count <= 11'(stored_r[MW'(q_cmd.metric)]);
              end else begin
                cnt_r <= stored_r[MW'(q_cmd.metric)];
                base_r <= (32'(stored_r[MW'(q_cmd.metric)]) < 32'(SAMPLES)) ? '0 :
                          head_r[MW'(q_cmd.metric)];
                pos_r <= (32'(stored_r[MW'(q_cmd.metric)]) < 32'(SAMPLES)) ? '0 :
                         head_r[MW'(q_cmd.metric)];
                i_r <= '0; vt_r <= '0;
                k_r <= '0;
                sum_r <= '0; c_r <= '0;
                if (q_cmd.op == bhra_pkg::OP_STATS) begin
                  hi_r <= stored_r[MW'(q_cmd.metric)];
                  mn_r <= 16'h7FFF; mx_r <= 16'h8000;
                  st_r <= S_SLOT;
                end else begin
                  rem_lo_r <= '0; rem_hi_r <= 32'(stored_r[MW'(q_cmd.metric)]);
                  qlo_r <= '0; qhi_r <= '0;
                  st_r <= S_SBND;
                end
              end
            end
          endcase
        end
        S_CLOSE: begin
          if (brd_r[m_r] == 16'd0) begin
            head_r[m_r] <= wrap_inc(head_r[m_r]);
            if (32'(stored_r[m_r]) < 32'(SAMPLES)) stored_r[m_r] <= stored_r[m_r] + CW'(1);
            if (32'(m_r) == 32'(METRICS - 1)) st_r <= S_IDLE;
            else m_r <= m_r + MW'(1);
          end else st_r <= S_CDIV;
        end
        S_CDIV: if (ddone) begin
          head_r[m_r] <= wrap_inc(head_r[m_r]);
          if (32'(stored_r[m_r]) < 32'(SAMPLES)) stored_r[m_r] <= stored_r[m_r] + CW'(1);
          bsum_r[m_r] <= '0; brd_r[m_r] <= '0;
          if (32'(m_r) == 32'(METRICS - 1)) st_r <= S_IDLE;
          else begin
            m_r <= m_r + MW'(1); st_r <= S_CLOSE;
          end
        end
        S_SBND: begin
          // Compute slot bounds by subtracting n repeatedly (one step per cycle).
          if (rem_lo_r >= 32'(cmd_r.slots)) begin
            rem_lo_r <= rem_lo_r - 32'(cmd_r.slots); qlo_r <= qlo_r + CW'(1);
          end else if (rem_hi_r >= 32'(cmd_r.slots)) begin
            rem_hi_r <= rem_hi_r - 32'(cmd_r.slots); qhi_r <= qhi_r + CW'(1);
          end else begin
            // Restart the walk at the lower bound; short histories make slots overlap.
            k_r <= qlo_r;
            pos_r <= (lo_pos >= 32'(SAMPLES)) ? SW'(lo_pos - 32'(SAMPLES)) : SW'(lo_pos);
            if (qhi_r > qlo_r) hi_r <= qhi_r;
            else if (32'(qlo_r) + 32'd1 > 32'(cnt_r)) hi_r <= cnt_r;
            else hi_r <= qlo_r + CW'(1);
            sum_r <= '0; c_r <= '0;
            st_r <= S_SLOT;
          end
        end
        S_SLOT: begin
          if (!walk_done) st_r <= S_RD;
          else if (c_r != 16'd0) st_r <= S_DIV;
          else st_r <= S_EMIT;
        end
        S_RD: begin
          st_r <= S_ACC;
        end
        S_ACC: begin
          if (rdata != no_data) begin
            sum_r <= sum_r + {{16{rv[15]}}, rdata};
            c_r <= c_r + 16'd1;
            if ($signed(rdata) < $signed(mn_r)) mn_r <= rdata;
            if ($signed(rdata) > $signed(mx_r)) mx_r <= rdata;
          end
          pos_r <= wrap_inc(pos_r);
          k_r <= k_r + CW'(1);
          st_r <= S_SLOT;
        end
        S_DIV: begin
          if (ddone) st_r <= S_EMIT;
        end
        S_EMIT: begin
          out_strobe <= 1'b1;
          out_sample_count <= '0;
          if (cmd_r.op == bhra_pkg::OP_STATS) begin
            out_slot_value <= '0; out_slot_has_data <= 1'b0; out_is_last <= 1'b1;
            out_valid_total <= '0;
            out_stats_ok <= (c_r != 16'd0);
            out_min_value <= (c_r != 16'd0) ? mn_r : '0;
            out_max_value <= (c_r != 16'd0) ? mx_r : '0;
            out_avg_value <= (c_r != 16'd0) ? dquo : '0;
            st_r <= S_IDLE;
          end else begin
            out_min_value <= '0; out_max_value <= '0; out_avg_value <= '0;
            out_stats_ok <= 1'b0;
            out_slot_has_data <= (c_r != 16'd0);
            out_slot_value <= (c_r != 16'd0) ? dquo : no_data;
            out_is_last <= (i_r + 7'd1 == cmd_r.slots);
            out_valid_total <= (i_r + 7'd1 == cmd_r.slots) ?
                               vt_r + {6'd0, c_r != 16'd0} : 7'd0;
            vt_r <= vt_r + {6'd0, c_r != 16'd0};
            i_r <= i_r + 7'd1;
            if (i_r + 7'd1 == cmd_r.slots) st_r <= S_IDLE;
            else begin
              // Next lower bound is this upper bound before adjustment.
              rem_lo_r <= rem_hi_r;
              qlo_r <= qhi_r;
              rem_hi_r <= rem_hi_r + prod;
              st_r <= S_SBND;
            end
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) out_strobe |-> !$past(out_strobe) ||
    $past(st_r) == S_EMIT || $past(st_r) == S_IDLE)
    else $error("unexpected strobe source");
  assert property (@(posedge clk) disable iff (!rst_n) (st_r == S_CLEAR) |-> !q_pop)
    else $error("command taken during clear");
  assert property (@(posedge clk) disable iff (!rst_n) we |-> (st_r == S_CLEAR ||
    st_r == S_CLOSE || st_r == S_CDIV))
    else $error("ring written outside close");
endmodule

// File: hdl/bucketed_history_ring_averager_top.sv
// Top level of the bucketed history ring averager.
// Instantiates bhra_front and bhra_back and holds the APB register block; uses bhra_pkg.
//
// Usage: drive in_operation/in_metric/in_sample_value/in_slot_count and pulse
// start while busy is low; the beat is taken at that edge. Adds and ticks give
// no result; series gives slot_count result beats (at most MAX_SLOTS), stats and
// span one each, a bad request one. Results appear on out_* for one cycle with
// out_strobe high; the receiver cannot stall, so no flow control exists there.
// A two-entry queue sits between the front end and the back end; busy is high
// while it is full. A tick that closes buckets writes each metric's ring entry
// in turn: a metric with readings first runs one 32-step divide of its sum by
// its reading count, an empty metric gets the no-data code directly. A series
// steps each slot's bounds by repeated subtraction, walks the ring entry by
// entry (slot, read, accumulate), divides each slot with data and drives one
// result beat per slot; stats walks every stored entry, then runs one divide
// if it found data. After reset the ring is cleared to the no-data code one
// entry per cycle, covering all METRICS*SAMPLES entries (5760 by default); up
// to two beats queue meanwhile, then busy holds the sender off.
// Configuration: APB writes at byte 0 (bucket_ticks) and 4 (no_data_code).
`timescale 1ns / 1ps
module bucketed_history_ring_averager_top #(
  parameter int METRICS   = bhra_pkg::METRICS_DEF,
  parameter int SAMPLES   = bhra_pkg::SAMPLES_DEF,
  parameter int MAX_SLOTS = bhra_pkg::MAX_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_operation,
  input  logic [3:0]  in_metric,
  input  logic [15:0] in_sample_value,
  input  logic [6:0]  in_slot_count,
  output logic        out_strobe,
  output logic [15:0] out_slot_value,
  output logic        out_slot_has_data,
  output logic        out_is_last,
  output logic [6:0]  out_valid_total,
  output logic [15:0] out_min_value,
  output logic [15:0] out_max_value,
  output logic [15:0] out_avg_value,
  output logic        out_stats_ok,
  output logic [10:0] out_sample_count,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [31:0] cfg_ticks_r;
  logic [15:0] cfg_nodata_r;
  logic        q_valid, q_pop;
  bhra_pkg::cmd_t q_cmd;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == bhra_pkg::REG_NO_DATA) ? {{16{cfg_nodata_r[15]}}, cfg_nodata_r}
                                                       : cfg_ticks_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_ticks_r  <= bhra_pkg::BUCKET_TICKS_RST;
      cfg_nodata_r <= bhra_pkg::NO_DATA_RST;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'd0) begin
      if (paddr[2] == bhra_pkg::REG_BUCKET_TICKS) cfg_ticks_r <= pwdata;
      else cfg_nodata_r <= pwdata[15:0];
    end
  end

  bhra_front #(.METRICS(METRICS), .MAX_SLOTS(MAX_SLOTS)) u_front (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .op(in_operation),
    .metric(in_metric), .value(in_sample_value), .slots(in_slot_count),
    .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop));

  bhra_back #(.METRICS(METRICS), .SAMPLES(SAMPLES)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop),
    .bucket_ticks(cfg_ticks_r), .no_data(cfg_nodata_r),
    .out_strobe(out_strobe), .out_slot_value(out_slot_value),
    .out_slot_has_data(out_slot_has_data), .out_is_last(out_is_last),
    .out_valid_total(out_valid_total), .out_min_value(out_min_value),
    .out_max_value(out_max_value), .out_avg_value(out_avg_value),
    .out_stats_ok(out_stats_ok), .out_sample_count(out_sample_count));
endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the bucketed history ring averager top level.
// Drives directed and random command beats plus APB register writes, and checks
// every result beat against an in-bench history-ring model or typed row; uses bhra_pkg.
`timescale 1ns / 1ps
module tb_top;
  localparam int NUM_METRICS = bhra_pkg::METRICS_DEF;
  localparam int RING_DEPTH  = bhra_pkg::SAMPLES_DEF;
  localparam int SLOT_LIMIT  = bhra_pkg::MAX_SLOTS_DEF;
  localparam int SETTLE      = 400;

  typedef struct {
    logic [15:0] slot_value;
    logic        has_data;
    logic        last;
    logic [6:0]  valid_total;
    logic [15:0] min_value;
    logic [15:0] max_value;
    logic [15:0] avg_value;
    logic        stats_ok;
    logic [10:0] sample_count;
  } result_t;

  typedef struct {
    logic [2:0]  op;
    logic [3:0]  metric;
    logic [15:0] value;
    logic [6:0]  slots;
    bit          typed;
    result_t     want;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  in_operation = '0;
  logic [3:0]  in_metric = '0;
  logic [15:0] in_sample_value = '0;
  logic [6:0]  in_slot_count = '0;
  logic        out_strobe;
  logic [15:0] out_slot_value;
  logic        out_slot_has_data;
  logic        out_is_last;
  logic [6:0]  out_valid_total;
  logic [15:0] out_min_value;
  logic [15:0] out_max_value;
  logic [15:0] out_avg_value;
  logic        out_stats_ok;
  logic [10:0] out_sample_count;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  always #2 clk = ~clk;

  bucketed_history_ring_averager_top u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_operation(in_operation), .in_metric(in_metric),
    .in_sample_value(in_sample_value), .in_slot_count(in_slot_count),
    .out_strobe(out_strobe), .out_slot_value(out_slot_value),
    .out_slot_has_data(out_slot_has_data), .out_is_last(out_is_last),
    .out_valid_total(out_valid_total), .out_min_value(out_min_value),
    .out_max_value(out_max_value), .out_avg_value(out_avg_value),
    .out_stats_ok(out_stats_ok), .out_sample_count(out_sample_count),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // History model
  shortint     hist_ring [NUM_METRICS][RING_DEPTH];
  int          hist_head [NUM_METRICS];
  int          hist_fill [NUM_METRICS];
  int          open_sum  [NUM_METRICS];
  int          open_reads[NUM_METRICS];
  int unsigned ms_count;
  int unsigned cfg_ticks;
  shortint     cfg_nodata;

  result_t     pending_beats[$];
  int          mismatches = 0;
  int          gap_mode = 1;

  function automatic result_t last_beat(int cnt);
    result_t r;
    r = '{default: '0};
    r.last = 1'b1;
    r.sample_count = 11'(cnt);
    return r;
  endfunction

  function automatic void reset_history();
    for (int m = 0; m < NUM_METRICS; m++) begin
      for (int i = 0; i < RING_DEPTH; i++) hist_ring[m][i] = shortint'(bhra_pkg::NO_DATA_RST);
      hist_head[m] = 0;
      hist_fill[m] = 0;
      open_sum[m] = 0;
      open_reads[m] = 0;
    end
    ms_count = 0;
    cfg_ticks = bhra_pkg::BUCKET_TICKS_RST;
    cfg_nodata = shortint'(bhra_pkg::NO_DATA_RST);
  endfunction

  function automatic void close_buckets();
    shortint v;
    for (int m = 0; m < NUM_METRICS; m++) begin
      v = cfg_nodata;
      if (open_reads[m] > 0) v = shortint'(open_sum[m] / open_reads[m]);
      hist_ring[m][hist_head[m]] = v;
      hist_head[m] = (hist_head[m] + 1) % RING_DEPTH;
      if (hist_fill[m] < RING_DEPTH) hist_fill[m]++;
      open_sum[m] = 0;
      open_reads[m] = 0;
    end
  endfunction

  // Update the history for one beat and queue the result beats it causes.
  function automatic void predict_beat(logic [2:0] op, logic [3:0] metric,
                                       logic [15:0] value, logic [6:0] slots);
    int m, cnt, first, nslot, lo, hi, c, sum, valid;
    shortint v, mn, mx;
    result_t r;
    m = metric;
    if (op == bhra_pkg::OP_ADD) begin
      if (m < NUM_METRICS && open_reads[m] < 65535) begin
        open_sum[m] += int'(shortint'(value));
        open_reads[m]++;
      end
      return;
    end
    if (op == bhra_pkg::OP_TICK) begin
      if (ms_count != 32'hFFFF_FFFF) ms_count++;
      if (ms_count >= cfg_ticks) begin
        ms_count = 0;
        close_buckets();
      end
      return;
    end
    if (op > bhra_pkg::OP_SPAN) return;
    if (m >= NUM_METRICS || (op == bhra_pkg::OP_SERIES && slots == 0)) begin
      pending_beats.push_back(last_beat(0));
      return;
    end
    cnt = hist_fill[m];
    first = (cnt < RING_DEPTH) ? 0 : hist_head[m];
    if (op == bhra_pkg::OP_SERIES) begin
      nslot = (slots > SLOT_LIMIT) ? SLOT_LIMIT : slots;
      valid = 0;
      for (int i = 0; i < nslot; i++) begin
        r = '{default: '0};
        r.slot_value = cfg_nodata;
        r.last = (i + 1 == nslot);
        if (cnt > 0) begin
          lo = i * cnt / nslot;
          hi = (i + 1) * cnt / nslot;
          if (hi <= lo) hi = lo + 1;
          if (hi > cnt) hi = cnt;
          c = 0;
          sum = 0;
          for (int k = lo; k < hi; k++) begin
            v = hist_ring[m][(first + k) % RING_DEPTH];
            if (v != cfg_nodata) begin
              sum += v;
              c++;
            end
          end
          if (c > 0) begin
            r.slot_value = 16'(sum / c);
            r.has_data = 1'b1;
            valid++;
          end
        end
        if (r.last) r.valid_total = 7'(valid);
        pending_beats.push_back(r);
      end
    end else if (op == bhra_pkg::OP_STATS) begin
      r = last_beat(0);
      mn = 16'sh7FFF;
      mx = 16'sh8000;
      c = 0;
      sum = 0;
      for (int k = 0; k < cnt; k++) begin
        v = hist_ring[m][(first + k) % RING_DEPTH];
        if (v != cfg_nodata) begin
          if (v < mn) mn = v;
          if (v > mx) mx = v;
          sum += v;
          c++;
        end
      end
      if (c > 0) begin
        r.min_value = mn;
        r.max_value = mx;
        r.avg_value = 16'(sum / c);
        r.stats_ok = 1'b1;
      end
      pending_beats.push_back(r);
    end else begin
      pending_beats.push_back(last_beat(cnt));
    end
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    result_t w;
    if (rst_n && out_strobe) begin
      if (pending_beats.size() == 0) begin
        $error("result beat with nothing pending");
        mismatches++;
      end else begin
        w = pending_beats.pop_front();
        check_field("slot_value", w.slot_value, out_slot_value);
        check_field("slot_has_data", 16'(w.has_data), 16'(out_slot_has_data));
        check_field("is_last", 16'(w.last), 16'(out_is_last));
        check_field("valid_total", 16'(w.valid_total), 16'(out_valid_total));
        check_field("min_value", w.min_value, out_min_value);
        check_field("max_value", w.max_value, out_max_value);
        check_field("avg_value", w.avg_value, out_avg_value);
        check_field("stats_ok", 16'(w.stats_ok), 16'(out_stats_ok));
        check_field("sample_count", 16'(w.sample_count), 16'(out_sample_count));
      end
    end
  end

  task automatic idle_gap();
    int g;
    case (gap_mode)
      0: g = 0;
      default: begin
        g = $urandom_range(0, 99);
        if (g < 50) g = 0;
        else if (g < 90) g = $urandom_range(1, 3);
        else g = $urandom_range(10, 60);
      end
    endcase
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // Present one beat and hold it until taken; call right after a rising edge.
  task automatic send_beat(logic [2:0] op, logic [3:0] metric, logic [15:0] value,
                           logic [6:0] slots, bit typed, result_t want);
    start <= 1'b1;
    in_operation <= op;
    in_metric <= metric;
    in_sample_value <= value;
    in_slot_count <= slots;
    do @(posedge clk); while (busy);
    if (typed) pending_beats.push_back(want);
    else predict_beat(op, metric, value, slots);
    idle_gap();
  endtask

  task automatic send_item(logic [2:0] op, logic [3:0] metric, logic [15:0] value,
                           logic [6:0] slots);
    send_beat(op, metric, value, slots, 1'b0, '{default: '0});
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic index, logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {index, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (index == bhra_pkg::REG_BUCKET_TICKS) cfg_ticks = data;
    else cfg_nodata = shortint'(data[15:0]);
    @(posedge clk);
  endtask

  task automatic random_items(int count, int read_pct);
    int pick;
    logic [2:0] op;
    logic [3:0] metric;
    logic [6:0] slots;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < read_pct) op = 3'($urandom_range(bhra_pkg::OP_SERIES, bhra_pkg::OP_SPAN));
      else if (pick < 97) op = ($urandom_range(0, 1) != 0) ? bhra_pkg::OP_ADD
                                                          : bhra_pkg::OP_TICK;
      else op = 3'($urandom_range(5, 7));
      metric = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                           : 4'($urandom_range(0, NUM_METRICS - 1));
      slots = ($urandom_range(0, 4) == 0) ? 7'($urandom_range(0, 127))
                                          : 7'($urandom_range(1, 8));
      send_item(op, metric, 16'($urandom), slots);
    end
  endtask

  row_t plan[$];

  initial begin
    reset_history();
    plan = '{
      '{bhra_pkg::OP_SPAN,   4'd0,  16'd0,    7'd0,   1'b1, last_beat(0)},
      '{bhra_pkg::OP_STATS,  4'd0,  16'd0,    7'd0,   1'b1, last_beat(0)},
      '{bhra_pkg::OP_SERIES, 4'd15, 16'd0,    7'd5,   1'b1, last_beat(0)},
      '{bhra_pkg::OP_SERIES, 4'd0,  16'd0,    7'd0,   1'b1, last_beat(0)},
      '{bhra_pkg::OP_STATS,  4'd4,  16'd0,    7'd1,   1'b1, last_beat(0)},
      '{bhra_pkg::OP_SPAN,   4'd9,  16'd0,    7'd1,   1'b1, last_beat(0)},
      '{bhra_pkg::OP_SERIES, 4'd1,  16'd0,    7'd3,   1'b0, '{default: '0}},
      '{bhra_pkg::OP_SERIES, 4'd3,  16'd0,    7'd127, 1'b0, '{default: '0}},
      '{3'd5,                4'd0,  16'd0,    7'd1,   1'b0, '{default: '0}},
      '{3'd6,                4'd2,  16'hFFFF, 7'd1,   1'b0, '{default: '0}},
      '{3'd7,                4'd15, 16'h5555, 7'd127, 1'b0, '{default: '0}},
      '{bhra_pkg::OP_ADD,    4'd0,  16'h7FFF, 7'd0,   1'b0, '{default: '0}},
      '{bhra_pkg::OP_ADD,    4'd0,  16'h8000, 7'd0,   1'b0, '{default: '0}},
      '{bhra_pkg::OP_ADD,    4'd1,  16'h8000, 7'd0,   1'b0, '{default: '0}},
      '{bhra_pkg::OP_ADD,    4'd3,  16'h7FFF, 7'd0,   1'b0, '{default: '0}},
      '{bhra_pkg::OP_ADD,    4'd15, 16'd123,  7'd0,   1'b0, '{default: '0}},
      '{bhra_pkg::OP_TICK,   4'd0,  16'd0,    7'd0,   1'b0, '{default: '0}},
      '{bhra_pkg::OP_SPAN,   4'd2,  16'd0,    7'd0,   1'b1, last_beat(0)},
      '{bhra_pkg::OP_SERIES, 4'd2,  16'd0,    7'd64,  1'b0, '{default: '0}}
    };
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i])
      send_beat(plan[i].op, plan[i].metric, plan[i].value, plan[i].slots,
                plan[i].typed, plan[i].want);
    drain();

    // Counter runs up against the widest setting, then the limit drops under it.
    write_reg(bhra_pkg::REG_BUCKET_TICKS, 32'hFFFF_FFFF);
    repeat (5) send_item(bhra_pkg::OP_TICK, 4'd0, 16'd0, 7'd0);
    drain();
    write_reg(bhra_pkg::REG_BUCKET_TICKS, 32'd1);
    send_item(bhra_pkg::OP_TICK, 4'd0, 16'd0, 7'd0);
    send_item(bhra_pkg::OP_SPAN, 4'd1, 16'd0, 7'd0);
    send_item(bhra_pkg::OP_SERIES, 4'd0, 16'd0, 7'd2);
    drain();

    // Zero limit closes on every tick.
    write_reg(bhra_pkg::REG_BUCKET_TICKS, 32'd0);
    random_items(60, 25);
    drain();

    // Closed average that lands on the sentinel reads back as empty.
    write_reg(bhra_pkg::REG_NO_DATA, 32'h0000_7FFF);
    repeat (3) send_item(bhra_pkg::OP_ADD, 4'd0, 16'h7FFF, 7'd0);
    send_item(bhra_pkg::OP_ADD, 4'd1, 16'h1234, 7'd0);
    send_item(bhra_pkg::OP_TICK, 4'd0, 16'd0, 7'd0);
    send_item(bhra_pkg::OP_SERIES, 4'd0, 16'd0, 7'd1);
    send_item(bhra_pkg::OP_STATS, 4'd0, 16'd0, 7'd0);
    send_item(bhra_pkg::OP_STATS, 4'd1, 16'd0, 7'd0);
    drain();

    // Pile extreme readings into one bucket, back to back.
    write_reg(bhra_pkg::REG_NO_DATA, 32'hFFFF_8000);
    gap_mode = 0;
    repeat (20) send_item(bhra_pkg::OP_ADD, 4'd2, 16'h8000, 7'd0);
    send_item(bhra_pkg::OP_ADD, 4'd2, 16'h7FFF, 7'd0);
    send_item(bhra_pkg::OP_TICK, 4'd0, 16'd0, 7'd0);
    send_item(bhra_pkg::OP_STATS, 4'd2, 16'd0, 7'd0);
    gap_mode = 1;
    drain();

    // Grow the histories, then read them with wide and narrow slot counts.
    gap_mode = 0;
    for (int i = 0; i < 30; i++) begin
      if ($urandom_range(0, 1) == 0)
        send_item(bhra_pkg::OP_ADD, 4'($urandom_range(0, NUM_METRICS - 1)), 16'($urandom),
                  7'd0);
      send_item(bhra_pkg::OP_TICK, 4'd0, 16'd0, 7'd0);
    end
    gap_mode = 1;
    send_item(bhra_pkg::OP_SPAN, 4'd3, 16'd0, 7'd0);
    send_item(bhra_pkg::OP_SERIES, 4'd1, 16'd0, 7'd64);
    send_item(bhra_pkg::OP_SERIES, 4'd2, 16'd0, 7'd7);
    send_item(bhra_pkg::OP_STATS, 4'd0, 16'd0, 7'd0);
    random_items(30, 25);
    drain();

    write_reg(bhra_pkg::REG_BUCKET_TICKS, 32'($urandom_range(2, 5)));
    write_reg(bhra_pkg::REG_NO_DATA, 32'($urandom_range(0, 65535)));
    random_items(50, 20);
    gap_mode = 0;
    random_items(20, 20);
    gap_mode = 1;
    drain();

    write_reg(bhra_pkg::REG_BUCKET_TICKS, 32'd60000);
    write_reg(bhra_pkg::REG_NO_DATA, 32'hFFFF_8000);
    random_items(30, 30);
    drain();

    if (mismatches == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #40ms;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule

// File: filelist.f
hdl/bhra_pkg.sv
hdl/bhra_ram.sv
hdl/bhra_front.sv
hdl/bhra_div.sv
hdl/bhra_back.sv
hdl/bucketed_history_ring_averager_top.sv
tb/tb_top.sv
